// ----- rtl/core/lzbd_pkg.sv -----
// Shared constants, types and codes of the LZ bitstream decompressor.
package lzbd_pkg;

    localparam int HISTORY_BITS  = 16;
    localparam int POSITION_BITS = 24;
    localparam int SIZE_W        = 24;
    localparam int ACC_W         = (HISTORY_BITS > 12) ? HISTORY_BITS : 12;
    localparam int FBD_W         = $clog2(ACC_W + 1);
    localparam int MW_W          = $clog2(HISTORY_BITS + 1);
    localparam int CMP_W         = ((POSITION_BITS > SIZE_W) ? POSITION_BITS : SIZE_W) + 1;
    localparam int PEND_W        = 12;
    localparam int Q_DEPTH       = 2;
    localparam int QP_W          = $clog2(Q_DEPTH);
    localparam int QC_W          = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_TRUNC   = 3'd1,
        ERR_RUN     = 3'd2,
        ERR_DIST    = 3'd3,
        ERR_OVERRUN = 3'd4,
        ERR_WIDTH   = 3'd5
    } t_err;

    typedef enum logic [2:0] {
        PH_FLAG, PH_LIT, PH_COUNT, PH_RUNLEN, PH_RUNBYTE, PH_DIST
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE, S_BITS, S_GROW, S_CP_RD, S_CP_WR, S_END
    } t_state;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       final_byte;
        logic       is_header;
    } t_item;

    typedef struct packed {
        logic [63:0] out_data;
        logic [3:0]  byte_count;
        logic        last;
        t_err        error_code;
    } t_result;

endpackage

// ----- rtl/core/lzbd_if.sv -----
// Channel interfaces: packed input bytes, result groups, size register write.
interface lzbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       final_byte;
    modport source (output valid, packed_byte, final_byte, input ready);
    modport sink (input valid, packed_byte, final_byte, output ready);
endinterface

interface lzbd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_data;
    logic [3:0]  byte_count;
    logic        last;
    logic [2:0]  error_code;
    modport source (output valid, out_data, byte_count, last, error_code, input ready);
    modport sink (input valid, out_data, byte_count, last, error_code, output ready);
endinterface

interface lzbd_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] output_size;
    modport source (output valid, output_size, input ready);
    modport sink (input valid, output_size, output ready);
endinterface

// ----- rtl/core/lzbd_front.sv -----
// Intake: tags the header byte and queues items for the decoder.
module lzbd_front import lzbd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lzbd_in_if.sink    i_in,
    output logic       o_q_valid,
    output t_item      o_q_item,
    input  logic       i_q_pop
);

    t_item             r_mem [Q_DEPTH];
    logic [QP_W-1:0]   r_wp, r_rp;
    logic [QC_W-1:0]   r_cnt;
    logic              r_hdr_seen;
    logic              w_push, w_pop;

    assign i_in.ready = (r_cnt != QC_W'(Q_DEPTH));
    assign w_push     = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_cnt != '0);
    assign w_pop      = o_q_valid && i_q_pop;
    assign o_q_item   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= '{packed_byte: i_in.packed_byte,
                             final_byte:  i_in.final_byte,
                             is_header:   !r_hdr_seen};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_rp       <= '0;
            r_cnt      <= '0;
            r_hdr_seen <= 1'b0;
        end else begin
            if (w_push) begin
                r_wp       <= r_wp + 1'b1;
                r_hdr_seen <= 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QC_W'(w_push) - QC_W'(w_pop);
        end
    end

endmodule

// ----- rtl/core/lzbd_back.sv -----
// Decoder: bit-serial field parse, history copy engine, byte packer, result register.
module lzbd_back import lzbd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    lzbd_out_if.source  o_out,
    lzbd_cfg_if.sink    i_cfg
);

    logic [7:0] r_hist [2**HISTORY_BITS];

    t_state                 r_state, n_state;
    t_phase                 r_phase, n_phase;
    logic [7:0]             r_sh, n_sh;
    logic [3:0]             r_bl, n_bl;
    logic [ACC_W-1:0]       r_acc, n_acc;
    logic [FBD_W-1:0]       r_fbd, n_fbd;
    logic [PEND_W-1:0]      r_pend, n_pend;
    logic [MW_W-1:0]        r_dw, n_dw, r_mw, n_mw;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [SIZE_W-1:0]      r_size;
    logic                   r_finished, n_finished;
    logic                   r_done, n_done;
    t_err                   r_err, n_err;
    logic                   r_fin, n_fin;
    logic [HISTORY_BITS-1:0] r_dist, n_dist;
    logic [63:0]            r_pack, n_pack;
    logic [3:0]             r_pcnt, n_pcnt;
    logic                   r_ov, n_ov;
    t_result                r_o, n_o;
    logic [7:0]             r_rdata;

    logic                   w_out_free, w_put_ok, w_bit, w_fdone, w_ge, w_inc_ge;
    logic                   w_grow, w_run_bad, w_dist_bad, w_ovr_bad;
    logic [FBD_W-1:0]       w_need;
    logic [ACC_W-1:0]       w_v;
    logic [POSITION_BITS-1:0] w_pos_inc;
    logic [HISTORY_BITS-1:0] w_raddr;
    logic                   w_put, w_rd_en;
    logic [7:0]             w_pb;
    t_err                   w_eff_err;

    assign i_cfg.ready     = 1'b1;
    assign o_out.valid      = r_ov;
    assign o_out.out_data   = r_o.out_data;
    assign o_out.byte_count = r_o.byte_count;
    assign o_out.last       = r_o.last;
    assign o_out.error_code = r_o.error_code;
    assign o_q_pop          = (r_state == S_IDLE);

    assign w_out_free = !r_ov || o_out.ready;
    assign w_put_ok   = (r_pcnt != 4'd8) || w_out_free;
    assign w_bit      = r_sh[7];
    assign w_v        = r_acc | (ACC_W'(w_bit) << r_fbd);
    assign w_fdone    = (r_fbd + 1'b1) >= w_need;
    assign w_pos_inc  = r_pos + 1'b1;
    assign w_ge       = CMP_W'(r_pos) >= CMP_W'(r_size);
    assign w_inc_ge   = CMP_W'(w_pos_inc) >= CMP_W'(r_size);
    assign w_grow     = ((r_pos >> r_dw) != '0) && (r_dw < r_mw);
    assign w_run_bad  = (w_v == '0) ||
                        (CMP_W'(r_pos) + CMP_W'(w_v) > CMP_W'(r_size));
    assign w_dist_bad = (w_v == '0) || (CMP_W'(w_v) > CMP_W'(r_pos));
    assign w_ovr_bad  = (CMP_W'(r_pos) + CMP_W'(r_pend) > CMP_W'(r_size));
    assign w_raddr    = r_pos[HISTORY_BITS-1:0] - r_dist;
    assign w_eff_err  = (r_err != ERR_NONE) ? r_err :
                        (!r_done && r_fin) ? ERR_TRUNC : ERR_NONE;

    always_comb begin
        unique case (r_phase)
            PH_RUNLEN: w_need = FBD_W'(12);
            PH_DIST:   w_need = FBD_W'(r_dw);
            default:   w_need = FBD_W'(8);
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && !r_finished) begin
                    n_state = i_q_item.is_header ? S_END : S_BITS;
                end
            end
            S_BITS: begin
                if (r_bl == '0 || (r_phase == PH_FLAG && w_ge)) begin
                    n_state = S_END;
                end else if (r_phase != PH_FLAG && w_fdone) begin
                    unique case (r_phase)
                        PH_LIT: if (w_put_ok && w_inc_ge) n_state = S_END;
                        PH_COUNT: if (w_v != '0) n_state = S_GROW;
                        PH_RUNLEN: if (w_run_bad) n_state = S_END;
                        PH_RUNBYTE: begin
                            if (w_put_ok && r_pend == PEND_W'(1) && w_inc_ge) n_state = S_END;
                        end
                        PH_DIST: n_state = (w_dist_bad || w_ovr_bad) ? S_END : S_CP_RD;
                        default: n_state = S_BITS;
                    endcase
                end
            end
            S_GROW: begin
                if (!w_grow) n_state = (r_dw == '0) ? S_END : S_BITS;
            end
            S_CP_RD: n_state = S_CP_WR;
            S_CP_WR: begin
                if (w_put_ok) begin
                    if (r_pend == PEND_W'(1)) n_state = w_inc_ge ? S_END : S_BITS;
                    else n_state = S_CP_RD;
                end
            end
            S_END: begin
                if (w_out_free && !(w_eff_err != ERR_NONE && r_pcnt == 4'd8)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_phase = r_phase;  n_sh = r_sh;   n_bl = r_bl;     n_acc = r_acc;
        n_fbd = r_fbd;      n_pend = r_pend; n_dw = r_dw;   n_mw = r_mw;
        n_pos = r_pos;      n_finished = r_finished;        n_done = r_done;
        n_err = r_err;      n_fin = r_fin; n_dist = r_dist; n_pack = r_pack;
        n_pcnt = r_pcnt;    n_o = r_o;
        n_ov = r_ov && !o_out.ready;
        w_put = 1'b0;       w_pb = '0;     w_rd_en = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && !r_finished) begin
                    n_fin = i_q_item.final_byte;
                    if (i_q_item.is_header) begin
                        if (i_q_item.packed_byte > 8'(HISTORY_BITS)) begin
                            n_err = ERR_WIDTH;
                        end else begin
                            n_mw   = MW_W'(i_q_item.packed_byte);
                            n_done = w_ge;
                        end
                    end else begin
                        n_sh = i_q_item.packed_byte;
                        n_bl = 4'd8;
                    end
                end
            end
            S_BITS: begin
                if (r_bl == '0) begin
                    n_bl = '0;
                end else if (r_phase == PH_FLAG && w_ge) begin
                    n_done = 1'b1;
                end else if (r_phase == PH_FLAG) begin
                    n_sh = r_sh << 1;  n_bl = r_bl - 1'b1;
                    n_phase = w_bit ? PH_COUNT : PH_LIT;
                    n_acc = '0;  n_fbd = '0;
                end else if (!w_fdone) begin
                    n_sh = r_sh << 1;  n_bl = r_bl - 1'b1;
                    n_acc = w_v;  n_fbd = r_fbd + 1'b1;
                end else begin
                    unique case (r_phase)
                        PH_LIT: begin
                            if (w_put_ok) begin
                                n_sh = r_sh << 1;  n_bl = r_bl - 1'b1;
                                n_acc = '0;  n_fbd = '0;
                                w_put = 1'b1;  w_pb = w_v[7:0];
                                n_phase = PH_FLAG;  n_done = w_inc_ge;
                            end
                        end
                        PH_COUNT: begin
                            n_sh = r_sh << 1;  n_bl = r_bl - 1'b1;
                            n_acc = '0;  n_fbd = '0;
                            if (w_v == '0) n_phase = PH_RUNLEN;
                            else n_pend = PEND_W'(w_v[7:0]) + PEND_W'(2);
                        end
                        PH_RUNLEN: begin
                            n_sh = r_sh << 1;  n_bl = r_bl - 1'b1;
                            n_acc = '0;  n_fbd = '0;
                            if (w_run_bad) n_err = ERR_RUN;
                            else begin
                                n_pend = w_v[PEND_W-1:0];
                                n_phase = PH_RUNBYTE;
                            end
                        end
                        PH_RUNBYTE: begin
                            if (w_put_ok) begin
                                n_sh = r_sh << 1;  n_bl = r_bl - 1'b1;
                                n_acc = '0;  n_fbd = '0;
                                w_put = 1'b1;  w_pb = w_v[7:0];
                                n_pend = r_pend - 1'b1;
                                if (r_pend == PEND_W'(1)) begin
                                    n_phase = PH_FLAG;  n_done = w_inc_ge;
                                end
                            end
                        end
                        PH_DIST: begin
                            n_sh = r_sh << 1;  n_bl = r_bl - 1'b1;
                            n_acc = '0;  n_fbd = '0;
                            if (w_dist_bad) n_err = ERR_DIST;
                            else if (w_ovr_bad) n_err = ERR_OVERRUN;
                            else n_dist = w_v[HISTORY_BITS-1:0];
                        end
                        default: begin
                            n_sh = r_sh << 1;  n_bl = r_bl - 1'b1;
                            n_phase = PH_FLAG;
                        end
                    endcase
                end
            end
            S_GROW: begin
                if (w_grow) n_dw = r_dw + 1'b1;
                else if (r_dw == '0) n_err = ERR_DIST;
                else n_phase = PH_DIST;
            end
            S_CP_RD: w_rd_en = 1'b1;
            S_CP_WR: begin
                if (w_put_ok) begin
                    w_put = 1'b1;  w_pb = r_rdata;
                    n_pend = r_pend - 1'b1;
                    if (r_pend == PEND_W'(1)) begin
                        n_phase = PH_FLAG;  n_done = w_inc_ge;
                    end
                end
            end
            S_END: begin
                if (w_out_free) begin
                    if (w_eff_err != ERR_NONE) begin
                        n_ov = 1'b1;
                        if (r_pcnt == 4'd8) begin
                            // full group decoded before the error still goes out
                            n_o = '{out_data: r_pack, byte_count: 4'd8, last: 1'b0,
                                    error_code: ERR_NONE};
                        end else begin
                            n_o = '{out_data: '0, byte_count: 4'd0, last: 1'b1,
                                    error_code: w_eff_err};
                            n_finished = 1'b1;
                            n_err = ERR_NONE;  n_done = 1'b0;
                        end
                    end else begin
                        if (r_pcnt != '0 || r_done) begin
                            n_ov = 1'b1;
                            n_o = '{out_data: r_pack, byte_count: r_pcnt, last: r_done,
                                    error_code: ERR_NONE};
                        end
                        n_finished = r_done;
                        n_done = 1'b0;
                    end
                    n_pack = '0;  n_pcnt = '0;
                end
            end
            default: n_ov = r_ov;
        endcase

        if (w_put) begin
            n_pos = w_pos_inc;
            if (r_pcnt == 4'd8) begin
                n_ov = 1'b1;
                n_o = '{out_data: r_pack, byte_count: 4'd8, last: 1'b0,
                        error_code: ERR_NONE};
                n_pack = 64'(w_pb);
                n_pcnt = 4'd1;
            end else begin
                n_pack = r_pack | (64'(w_pb) << {r_pcnt[2:0], 3'b000});
                n_pcnt = r_pcnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_hist[r_pos[HISTORY_BITS-1:0]] <= w_pb;
        end
        if (w_rd_en) begin
            r_rdata <= r_hist[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_o <= n_o;
        if (!i_rst_n) begin
            r_state <= S_IDLE;     r_phase <= PH_FLAG;
            r_sh <= '0;  r_bl <= '0;  r_acc <= '0;  r_fbd <= '0;  r_pend <= '0;
            r_dw <= '0;  r_mw <= '0;  r_pos <= '0;  r_size <= '0;
            r_finished <= 1'b0;  r_done <= 1'b0;  r_err <= ERR_NONE;  r_fin <= 1'b0;
            r_dist <= '0;  r_pack <= '0;  r_pcnt <= '0;  r_ov <= 1'b0;
        end else begin
            r_state <= n_state;    r_phase <= n_phase;
            r_sh <= n_sh;  r_bl <= n_bl;  r_acc <= n_acc;  r_fbd <= n_fbd;
            r_pend <= n_pend;  r_dw <= n_dw;  r_mw <= n_mw;  r_pos <= n_pos;
            r_finished <= n_finished;  r_done <= n_done;  r_err <= n_err;
            r_fin <= n_fin;  r_dist <= n_dist;  r_pack <= n_pack;  r_pcnt <= n_pcnt;
            r_ov <= n_ov;
            if (i_cfg.valid) begin
                r_size <= i_cfg.output_size;
            end
        end
    end

`ifndef ASSERT_OFF
    a_pcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt <= 4'd8) else $error("packer count above eight");
    a_copy_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CP_RD |=> r_state == S_CP_WR) else $error("copy read not followed by write");
    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o.error_code != ERR_NONE) |-> (r_o.byte_count == 4'd0 && r_o.last))
        else $error("error result carries bytes");
    a_finished_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |=> r_finished) else $error("finished flag dropped");
`endif

endmodule

// ----- rtl/core/lz_bitstream_decompressor.sv -----
// Top level of the LZ bitstream decompressor.
// Usage: write output_size on i_cfg while idle, then feed the packed stream on
// i_in one byte per transfer; the first byte is the header (max distance width),
// final_byte marks the last byte. Results leave on o_out as groups of up to eight
// bytes, earliest in bits 7:0; last marks the end of the stream or an error
// result (byte_count 0, error_code nonzero).
// Flow: a two-entry queue takes bytes while the decoder works. The decoder
// handles the header in its idle and end states; a body byte is popped while
// idle, parsed bit by bit and closed in the end state (bits after the stream's
// end are skipped). A back-reference first widens the distance field as needed,
// one width step at a time; its copy then reads the history, then writes.
// A result waits in the output register; while o_out.ready is low the decoder
// stalls at the next byte that needs to flush a full group or at the end of
// the current byte, and intake stops once the queue is full. Once the stream
// is done or failed, further bytes are taken and dropped without results.
// Reset clears all control state and output_size; the history memory holds
// garbage until written and is never read before that.
module lz_bitstream_decompressor import lzbd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lzbd_in_if.sink     i_in,
    lzbd_out_if.source  o_out,
    lzbd_cfg_if.sink    i_cfg
);

    logic  w_q_valid;
    logic  w_q_pop;
    t_item w_q_item;

    lzbd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_pop   (w_q_pop)
    );

    lzbd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .o_out     (o_out),
        .i_cfg     (i_cfg)
    );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench of the LZ bitstream decompressor: encoded streams, size writes, predictor.
module tb;
    import lzbd_pkg::*;

    typedef enum int {ROW_LIT, ROW_MATCH, ROW_RUN} t_row_kind;
    typedef struct {
        t_row_kind kind;
        int        a;      // literal value, match count or run length
        int        b;      // match distance, 0 means farthest
    } t_row;
    typedef enum int {END_DONE, END_TRUNC, END_BADRUN, END_BADDIST, END_OVERRUN} t_end_mode;

    localparam int HDR_WIDTH = 16;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    lzbd_in_if  in_if();
    lzbd_out_if out_if();
    lzbd_cfg_if cfg_if();

    lz_bitstream_decompressor dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .o_out  (out_if.source),
        .i_cfg  (cfg_if.sink)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #20000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------- predictor state ----------------
    logic [23:0]  dec_size;
    bit           dec_hdr_seen;
    int unsigned  dec_max_w;
    t_phase       dec_phase;
    int unsigned  dec_acc;
    int unsigned  dec_bits;
    int unsigned  dec_pend;
    int unsigned  dec_dw;
    int unsigned  dec_pos;
    bit           dec_done;
    logic [7:0]   hist_mem [0:65535];
    logic [7:0]   step_bytes[$];
    t_result      expected_groups[$];
    int           fails = 0;
    logic [2:0]   last_code;
    bit           saw_last = 0;

    function automatic void emit_byte(logic [7:0] v);
        hist_mem[dec_pos[15:0]] = v;
        step_bytes.push_back(v);
        dec_pos = (dec_pos + 1) & 32'hFFFFFF;
    endfunction

    function automatic int item_end();
        dec_phase = PH_FLAG;
        return (dec_pos >= dec_size) ? -1 : 0;
    endfunction

    // 0 continue, -1 stream done, >0 error code
    function automatic int take_bit(logic bitv);
        int unsigned need;
        int unsigned v;
        int unsigned i;
        if (dec_phase == PH_FLAG) begin
            dec_phase = bitv ? PH_COUNT : PH_LIT;
            dec_acc = 0;
            dec_bits = 0;
            return 0;
        end
        if (dec_bits < 32) dec_acc |= 32'(bitv) << dec_bits;
        dec_bits++;
        need = (dec_phase == PH_RUNLEN) ? 12 : (dec_phase == PH_DIST) ? dec_dw : 8;
        if (dec_bits < need) return 0;
        v = dec_acc;
        dec_acc = 0;
        dec_bits = 0;
        case (dec_phase)
            PH_LIT: begin
                emit_byte(v[7:0]);
                return item_end();
            end
            PH_COUNT: begin
                if (v == 0) begin
                    dec_phase = PH_RUNLEN;
                    return 0;
                end
                dec_pend = v + 2;
                while (64'(dec_pos) >= (64'd1 << dec_dw) && dec_dw < dec_max_w) dec_dw++;
                if (dec_dw == 0) return ERR_DIST;
                dec_phase = PH_DIST;
                return 0;
            end
            PH_RUNLEN: begin
                if (v == 0 || 64'(dec_pos) + v > dec_size) return ERR_RUN;
                dec_pend = v;
                dec_phase = PH_RUNBYTE;
                return 0;
            end
            PH_RUNBYTE: begin
                emit_byte(v[7:0]);
                if (dec_pend > 0) dec_pend--;
                if (dec_pend == 0) return item_end();
                return 0;
            end
            PH_DIST: begin
                if (v == 0 || v > dec_pos) return ERR_DIST;
                if (64'(dec_pos) + dec_pend > dec_size) return ERR_OVERRUN;
                for (i = 0; i < dec_pend; i++) emit_byte(hist_mem[16'(dec_pos - v)]);
                dec_pend = 0;
                return item_end();
            end
            default: begin
                dec_phase = PH_FLAG;
                return 0;
            end
        endcase
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic fin);
        int err;
        int r;
        bit done;
        int k;
        int full;
        int rem;
        int g;
        int j;
        t_result res;
        err = 0;
        done = 0;
        if (dec_done) return;
        step_bytes.delete();
        if (!dec_hdr_seen) begin
            dec_hdr_seen = 1;
            if (b > HISTORY_BITS) err = ERR_WIDTH;
            else begin
                dec_max_w = b;
                if (dec_pos >= dec_size) done = 1;
            end
        end else begin
            for (k = 7; k >= 0; k--) begin
                if (dec_phase == PH_FLAG && dec_pos >= dec_size) begin
                    done = 1;
                    break;
                end
                r = take_bit(b[k]);
                if (r < 0) begin
                    done = 1;
                    break;
                end
                if (r > 0) begin
                    err = r;
                    break;
                end
            end
        end
        if (err == 0 && !done && fin) err = ERR_TRUNC;
        if (err != 0 || done) dec_done = 1;
        full = step_bytes.size() / 8;
        rem = step_bytes.size() % 8;
        for (g = 0; g < full; g++) begin
            res = '0;
            for (j = 0; j < 8; j++) res.out_data[8*j +: 8] = step_bytes[g*8 + j];
            res.byte_count = 4'd8;
            res.last = (err == 0 && done && rem == 0 && g + 1 == full);
            res.error_code = ERR_NONE;
            expected_groups.push_back(res);
        end
        if (err != 0) begin
            res = '0;
            res.last = 1'b1;
            res.error_code = t_err'(err);
            expected_groups.push_back(res);
        end else if (rem > 0 || (done && step_bytes.size() == 0)) begin
            res = '0;
            for (j = 0; j < rem; j++) res.out_data[8*j +: 8] = step_bytes[full*8 + j];
            res.byte_count = 4'(rem);
            res.last = done;
            res.error_code = ERR_NONE;
            expected_groups.push_back(res);
        end
    endfunction

    // ---------------- monitors ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dec_size = '0;
            dec_hdr_seen = 0;
            dec_max_w = 0;
            dec_phase = PH_FLAG;
            dec_acc = 0;
            dec_bits = 0;
            dec_pend = 0;
            dec_dw = 0;
            dec_pos = 0;
            dec_done = 0;
        end else begin
            if (cfg_if.valid && cfg_if.ready) dec_size = cfg_if.output_size;
            if (in_if.valid && in_if.ready) decode_byte(in_if.packed_byte, in_if.final_byte);
            if (out_if.valid && out_if.ready) begin
                if (expected_groups.size() == 0) begin
                    $error("unexpected result data=%h count=%0d", out_if.out_data,
                           out_if.byte_count);
                    fails++;
                end else begin
                    t_result e;
                    e = expected_groups.pop_front();
                    if (out_if.out_data !== e.out_data) begin
                        $error("out_data exp %h got %h", e.out_data, out_if.out_data);
                        fails++;
                    end
                    if (out_if.byte_count !== e.byte_count) begin
                        $error("byte_count exp %0d got %0d", e.byte_count, out_if.byte_count);
                        fails++;
                    end
                    if (out_if.last !== e.last) begin
                        $error("last exp %0b got %0b", e.last, out_if.last);
                        fails++;
                    end
                    if (out_if.error_code !== e.error_code) begin
                        $error("error_code exp %0d got %0d", e.error_code, out_if.error_code);
                        fails++;
                    end
                end
                if (out_if.last === 1'b1) begin
                    saw_last = 1;
                    last_code = out_if.error_code;
                end
            end
        end
    end

    // ---------------- receiver ----------------
    bit hold_go = 0;
    int hold_left = 0;
    int rx_mode = 0;
    int rx_cyc = 0;

    always @(posedge i_clk) begin
        rx_cyc++;
        if (rx_cyc % 64 == 0) rx_mode = $urandom_range(0, 2);
        if (hold_go) begin
            hold_go = 0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else case (rx_mode)
            0: out_if.ready <= 1'b1;
            1: out_if.ready <= ($urandom_range(0, 3) != 0);
            default: out_if.ready <= rx_cyc[2];
        endcase
    end

    // ---------------- stream encoder ----------------
    bit          enc_bits[$];
    logic [7:0]  enc_bytes[$];
    int unsigned enc_pos;
    int unsigned enc_dw;

    function automatic void put_field(int unsigned v, int n);
        int i;
        for (i = 0; i < n; i++) enc_bits.push_back(v[i]);
    endfunction

    function automatic void enc_literal(int v);
        enc_bits.push_back(1'b0);
        put_field(v, 8);
        enc_pos++;
    endfunction

    // back distance 0 picks the farthest legal one
    function automatic void enc_match(int v, int back_dist);
        enc_bits.push_back(1'b1);
        put_field(v, 8);
        while (enc_pos >= (1 << enc_dw) && enc_dw < HDR_WIDTH) enc_dw++;
        if (back_dist == 0 || back_dist > enc_pos) back_dist = enc_pos;
        put_field(back_dist, enc_dw);
        enc_pos += v + 2;
    endfunction

    function automatic void enc_run(int n);
        int i;
        enc_bits.push_back(1'b1);
        put_field(0, 8);
        put_field(n, 12);
        for (i = 0; i < n; i++) put_field($urandom_range(0, 255), 8);
        enc_pos += n;
    endfunction

    function automatic void pack_bits();
        logic [7:0] b;
        int i;
        while (enc_bits.size() > 0) begin
            b = '0;
            for (i = 7; i >= 0; i--) if (enc_bits.size() > 0) b[i] = enc_bits.pop_front();
            enc_bytes.push_back(b);
        end
    endfunction

    // ---------------- sender ----------------
    int burst_left = 0;

    task automatic send_byte(logic [7:0] b, logic fin);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                in_if.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        in_if.valid <= 1'b1;
        in_if.packed_byte <= b;
        in_if.final_byte <= fin;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic write_size(logic [23:0] v);
        in_if.valid <= 1'b0;
        while (expected_groups.size() != 0) @(posedge i_clk);
        repeat (800) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.output_size <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    t_row directed_rows[] = '{
        '{ROW_LIT, 8'h00, 0}, '{ROW_LIT, 8'hFF, 0}, '{ROW_LIT, 8'h5A, 0},
        '{ROW_MATCH, 1, 1}, '{ROW_LIT, 8'hA5, 0}, '{ROW_MATCH, 255, 0},
        '{ROW_RUN, 1, 0}, '{ROW_RUN, 9, 0}, '{ROW_MATCH, 6, 2},
        '{ROW_LIT, 8'h81, 0}, '{ROW_MATCH, 30, 0}, '{ROW_RUN, 3, 0}
    };

    initial begin
        t_end_mode   mode;
        int          i;
        int          n;
        int          sel;
        int          phase_len;
        logic [23:0] end_size;
        logic [2:0]  end_code;

        in_if.valid = 1'b0;
        in_if.packed_byte = '0;
        in_if.final_byte = 1'b0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.output_size = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        enc_pos = 0;
        enc_dw = 0;
        foreach (directed_rows[r]) begin
            case (directed_rows[r].kind)
                ROW_LIT:   enc_literal(directed_rows[r].a);
                ROW_MATCH: enc_match(directed_rows[r].a, directed_rows[r].b);
                default:   enc_run(directed_rows[r].a);
            endcase
        end
        // random body: mostly short items, a few long copies
        while (enc_bits.size() < 330 * 8) begin
            sel = $urandom_range(0, 9);
            if (sel < 5) enc_literal($urandom_range(0, 255));
            else if (sel < 8) enc_match(($urandom_range(0, 15) == 0) ? $urandom_range(1, 255)
                                                                    : $urandom_range(1, 8),
                                        $urandom_range(0, 40));
            else enc_run($urandom_range(1, 6));
        end

        mode = t_end_mode'($urandom_range(0, 4));
        end_size = 24'hFFFFFF;
        case (mode)
            END_DONE:    begin
                end_size = ($urandom_range(0, 3) == 0) ? 24'd0 : 24'(enc_pos);
                end_code = ERR_NONE;
            end
            END_TRUNC:   end_code = ERR_TRUNC;
            END_BADRUN:  begin
                enc_bits.push_back(1'b1);
                put_field(0, 8);
                put_field(0, 12);
                end_code = ERR_RUN;
            end
            END_BADDIST: begin
                enc_bits.push_back(1'b1);
                put_field($urandom_range(1, 255), 8);
                put_field(0, HDR_WIDTH);
                end_code = ERR_DIST;
            end
            default:     begin
                end_size = 24'(enc_pos + 1);
                enc_bits.push_back(1'b1);
                put_field($urandom_range(1, 255), 8);
                put_field(1, HDR_WIDTH);
                end_code = ERR_OVERRUN;
            end
        endcase
        pack_bits();

        write_size(24'hFFFFFF);
        send_byte(8'(HDR_WIDTH), 1'b0);
        i = 0;
        n = enc_bytes.size();
        while (i < n - 40) begin
            phase_len = $urandom_range(40, 80);
            while (phase_len > 0 && i < n - 40) begin
                if (i == 120) hold_go = 1;
                send_byte(enc_bytes[i], 1'b0);
                i++;
                phase_len--;
            end
            if (i < n - 40) write_size(24'($urandom_range(24'h100000, 24'hFFFFFF)));
        end
        write_size(end_size);
        while (i < n) begin
            send_byte(enc_bytes[i], i == n - 1);
            i++;
        end
        // stream is over; these are dropped
        repeat (5) send_byte($urandom_range(0, 255), $urandom_range(0, 1));
        in_if.valid <= 1'b0;

        while (expected_groups.size() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
        if (!saw_last || last_code !== end_code) begin
            $error("end error_code exp %0d got %0d", end_code, last_code);
            fails++;
        end
        if (expected_groups.size() != 0) begin
            $error("%0d results never arrived", expected_groups.size());
            fails++;
        end
        if (fails == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule
